@@ hw/rtl/trast_pkg.sv @@
// Shared types, codes and constants of the triangle edge rasterizer.
// No dependencies; the channel interfaces and the top level import it.
package trast_pkg;

	// Coordinate width default and fixed field widths
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAME_MAX      = 2048;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int PIX_W          = 11;

	// Register reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Input transaction kinds
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} kind_t;

	// Largest usable coordinate for a frame size register: zero acts as one,
	// anything above the frame limit acts as the limit.
	function automatic logic [PIX_W-1:0] frame_max(input logic [CFG_W-1:0] r);
		logic [CFG_W-1:0] m;
		if (r == '0) begin
			m = '0;
		end else if (r > CFG_W'(FRAME_MAX)) begin
			m = CFG_W'(FRAME_MAX - 1);
		end else begin
			m = r - CFG_W'(1);
		end
		return m[PIX_W-1:0];
	endfunction

endpackage

@@ hw/rtl/trast_ifs.sv @@
// Valid/ready channel interfaces of the triangle edge rasterizer:
// triangle/step transactions in, pixel transactions out. Uses trast_pkg.

// Triangle load or step transaction
interface trast_tri_if
	import trast_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] vertex_a_x;
	logic signed [COORD_BITS-1:0] vertex_a_y;
	logic signed [COORD_BITS-1:0] vertex_b_x;
	logic signed [COORD_BITS-1:0] vertex_b_y;
	logic signed [COORD_BITS-1:0] vertex_c_x;
	logic signed [COORD_BITS-1:0] vertex_c_y;

	modport source (
		output valid, kind, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		       vertex_c_x, vertex_c_y,
		input  ready
	);
	modport sink (
		input  valid, kind, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		       vertex_c_x, vertex_c_y,
		output ready
	);
endinterface

// Visited pixel transaction
interface trast_pix_if
	import trast_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic             covered;
	logic             last;

	modport source (
		output valid, pixel_x, pixel_y, covered, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, covered, last,
		output ready
	);
endinterface

@@ hw/rtl/triangle_edge_rasterizer_unit.sv @@
// Edge-function triangle rasterizer: bounding-box setup pipeline and pixel walker.
// Depends on trast_pkg and the channel interfaces in trast_ifs.sv.
//
//  channel    dir  handshake     payload
//  tri_ch     in   valid/ready   kind, vertex_{a,b,c}_{x,y}
//  pix_ch     out  valid/ready   pixel_x, pixel_y, covered, last
//  cfg_*      in   cfg_we        cfg_index, cfg_wdata (frame_width, frame_height)
//
// One transaction is taken per clock while tri_ch is ready. Each passes three pipeline
// stages (box clamp, edge multiplies, edge sums and walk update), and a step's pixel
// moves from the stage 3 register into the output register once pix_ch can take it.
// arst_n clears the walker to idle and the frame size to 640 x 480.
// A stalled pix_ch holds the output register; stages behind it keep filling
// bubbles, and tri_ch drops ready only when every stage is full.
module triangle_edge_rasterizer_unit
	import trast_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	trast_tri_if.sink            tri_ch,
	trast_pix_if.source          pix_ch
);

	localparam int DW = COORD_BITS + 1;            // edge steps and offsets
	localparam int WW = (DW > CFG_W) ? DW : CFG_W; // box compare width
	localparam int PW = 2 * DW;                    // one product
	localparam int EW = 2 * COORD_BITS + 4;        // edge values

	// ---------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------
	function automatic logic signed [WW-1:0] widen(input logic signed [COORD_BITS-1:0] v);
		return WW'(v);
	endfunction

	function automatic logic signed [WW-1:0] min3(input logic signed [WW-1:0] a,
		input logic signed [WW-1:0] b, input logic signed [WW-1:0] c);
		logic signed [WW-1:0] r;
		r = (a < b) ? a : b;
		return (r < c) ? r : c;
	endfunction

	function automatic logic signed [WW-1:0] max3(input logic signed [WW-1:0] a,
		input logic signed [WW-1:0] b, input logic signed [WW-1:0] c);
		logic signed [WW-1:0] r;
		r = (a > b) ? a : b;
		return (r > c) ? r : c;
	endfunction

	function automatic logic [PIX_W-1:0] clamp_box(input logic signed [WW-1:0] v,
		input logic [PIX_W-1:0] hi);
		logic signed [WW-1:0] hiw;
		hiw = WW'($signed({1'b0, hi}));
		if (v < 0) begin
			return '0;
		end else if (v > hiw) begin
			return hi;
		end
		return v[PIX_W-1:0];
	endfunction

	// Offset of a clamped corner from a vertex; the true value fits in DW bits
	function automatic logic signed [DW-1:0] offset(input logic [PIX_W-1:0] p,
		input logic signed [WW-1:0] v);
		logic signed [WW-1:0] t;
		t = $signed(WW'({1'b0, p})) - v;
		return t[DW-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] frame_w_q;
	logic [CFG_W-1:0] frame_h_q;
	logic [PIX_W-1:0] wmax;
	logic [PIX_W-1:0] hmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FRAME_WIDTH_RST;
			frame_h_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_w_q <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign wmax = frame_max(frame_w_q);
	assign hmax = frame_max(frame_h_q);

	// ---------------------------------------------------------------
	// Flow control
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic kind_s1, kind_s2, kind_s3;
	logic rdy1, rdy2, rdy3;
	logic out_valid_q;
	logic out_free;
	logic busy_q;
	logic step_live;
	logic step_go;
	logic load_go;

	assign out_free  = !out_valid_q || pix_ch.ready;
	assign step_live = v_s3 && (kind_s3 == KIND_STEP) && busy_q;
	assign load_go   = v_s3 && (kind_s3 == KIND_LOAD);
	assign step_go   = step_live && out_free;
	assign rdy3      = !v_s3 || !step_live || out_free;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign tri_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= tri_ch.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && tri_ch.valid) begin
			kind_s1 <= tri_ch.kind;
			ax_s1   <= tri_ch.vertex_a_x;
			ay_s1   <= tri_ch.vertex_a_y;
			bx_s1   <= tri_ch.vertex_b_x;
			by_s1   <= tri_ch.vertex_b_y;
			cx_s1   <= tri_ch.vertex_c_x;
			cy_s1   <= tri_ch.vertex_c_y;
		end
	end

	// ---------------------------------------------------------------
	// Box clamp, edge steps and corner offsets
	// ---------------------------------------------------------------
	logic signed [WW-1:0] axw, ayw, bxw, byw, cxw, cyw;
	logic [PIX_W-1:0]     x0_c, x1_c, y0_c, y1_c;
	logic signed [DW-1:0] i_c [3];
	logic signed [DW-1:0] j_c [3];
	logic signed [DW-1:0] dx_c [3];
	logic signed [DW-1:0] dy_c [3];

	always_comb begin
		axw = widen(ax_s1);
		ayw = widen(ay_s1);
		bxw = widen(bx_s1);
		byw = widen(by_s1);
		cxw = widen(cx_s1);
		cyw = widen(cy_s1);
		x0_c = clamp_box(min3(axw, bxw, cxw), wmax);
		x1_c = clamp_box(max3(axw, bxw, cxw), wmax);
		y0_c = clamp_box(min3(ayw, byw, cyw), hmax);
		y1_c = clamp_box(max3(ayw, byw, cyw), hmax);
		// Edges a->b, b->c, c->a; E = I*(x - xs) + J*(y - ys) from the edge start
		i_c[0] = DW'(ay_s1) - DW'(by_s1);
		j_c[0] = DW'(bx_s1) - DW'(ax_s1);
		i_c[1] = DW'(by_s1) - DW'(cy_s1);
		j_c[1] = DW'(cx_s1) - DW'(bx_s1);
		i_c[2] = DW'(cy_s1) - DW'(ay_s1);
		j_c[2] = DW'(ax_s1) - DW'(cx_s1);
		dx_c[0] = offset(x0_c, axw);
		dy_c[0] = offset(y0_c, ayw);
		dx_c[1] = offset(x0_c, bxw);
		dy_c[1] = offset(y0_c, byw);
		dx_c[2] = offset(x0_c, cxw);
		dy_c[2] = offset(y0_c, cyw);
	end

	// ---------------------------------------------------------------
	// Stage 2 register
	// ---------------------------------------------------------------
	logic signed [DW-1:0] i_s2 [3];
	logic signed [DW-1:0] j_s2 [3];
	logic signed [DW-1:0] dx_s2 [3];
	logic signed [DW-1:0] dy_s2 [3];
	logic [PIX_W-1:0]     x0_s2, x1_s2, y0_s2, y1_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			kind_s2 <= kind_s1;
			x0_s2   <= x0_c;
			x1_s2   <= x1_c;
			y0_s2   <= y0_c;
			y1_s2   <= y1_c;
			for (int e = 0; e < 3; e++) begin
				i_s2[e]  <= i_c[e];
				j_s2[e]  <= j_c[e];
				dx_s2[e] <= dx_c[e];
				dy_s2[e] <= dy_c[e];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 3 register: edge products
	// ---------------------------------------------------------------
	logic signed [DW-1:0] i_s3 [3];
	logic signed [DW-1:0] j_s3 [3];
	logic signed [PW-1:0] px_s3 [3];
	logic signed [PW-1:0] py_s3 [3];
	logic [PIX_W-1:0]     x0_s3, x1_s3, y0_s3, y1_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			kind_s3 <= kind_s2;
			x0_s3   <= x0_s2;
			x1_s3   <= x1_s2;
			y0_s3   <= y0_s2;
			y1_s3   <= y1_s2;
			for (int e = 0; e < 3; e++) begin
				i_s3[e]  <= i_s2[e];
				j_s3[e]  <= j_s2[e];
				px_s3[e] <= i_s2[e] * dx_s2[e];
				py_s3[e] <= j_s2[e] * dy_s2[e];
			end
		end
	end

	// ---------------------------------------------------------------
	// Walker state
	// ---------------------------------------------------------------
	logic [PIX_W-1:0] walk_x_q, walk_y_q;
	logic [PIX_W-1:0] box_left_q, box_right_q, box_bottom_q;
	logic signed [DW-1:0] inc_x_q [3];
	logic signed [DW-1:0] inc_y_q [3];
	logic signed [EW-1:0] row_q [3];
	logic signed [EW-1:0] pix_q [3];
	logic covered;
	logic fin;
	logic row_end;

	assign covered = !pix_q[0][EW-1] && !pix_q[1][EW-1] && !pix_q[2][EW-1];
	assign row_end = (walk_x_q == box_right_q);
	assign fin     = row_end && (walk_y_q == box_bottom_q);

	// Start a walk on a load, advance it on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			walk_x_q     <= '0;
			walk_y_q     <= '0;
			box_left_q   <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (load_go) begin
			busy_q       <= 1'b1;
			walk_x_q     <= x0_s3;
			walk_y_q     <= y0_s3;
			box_left_q   <= x0_s3;
			box_right_q  <= x1_s3;
			box_bottom_q <= y1_s3;
		end else if (step_go) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else if (row_end) begin
				walk_x_q <= box_left_q;
				walk_y_q <= walk_y_q + PIX_W'(1);
			end else begin
				walk_x_q <= walk_x_q + PIX_W'(1);
			end
		end
	end

	// Edge values: seed at the box corner, then add steps as the walk moves
	always_ff @(posedge clk) begin
		for (int e = 0; e < 3; e++) begin
			if (load_go) begin
				inc_x_q[e] <= i_s3[e];
				inc_y_q[e] <= j_s3[e];
				row_q[e]   <= EW'(px_s3[e]) + EW'(py_s3[e]);
				pix_q[e]   <= EW'(px_s3[e]) + EW'(py_s3[e]);
			end else if (step_go && !fin) begin
				if (row_end) begin
					row_q[e] <= row_q[e] + EW'(inc_y_q[e]);
					pix_q[e] <= row_q[e] + EW'(inc_y_q[e]);
				end else begin
					pix_q[e] <= pix_q[e] + EW'(inc_x_q[e]);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [PIX_W-1:0] out_x_q, out_y_q;
	logic             out_cov_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go) begin
			out_valid_q <= 1'b1;
		end else if (pix_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			out_x_q    <= walk_x_q;
			out_y_q    <= walk_y_q;
			out_cov_q  <= covered;
			out_last_q <= fin;
		end
	end

	assign pix_ch.valid   = out_valid_q;
	assign pix_ch.pixel_x = out_x_q;
	assign pix_ch.pixel_y = out_y_q;
	assign pix_ch.covered = out_cov_q;
	assign pix_ch.last    = out_last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// The walker never leaves its box
	a_walk_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (walk_x_q >= box_left_q) && (walk_x_q <= box_right_q) &&
		           (walk_y_q <= box_bottom_q))
		else $error("walker outside its bounding box");

	// Input backpressure only comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_ch.ready |-> (pix_ch.valid && !pix_ch.ready))
		else $error("input stalled without output backpressure");

	// A committed load always starts a walk
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> busy_q)
		else $error("load did not start a walk");

	// At the start of a row the pixel values equal the row values
	a_row_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (walk_x_q == box_left_q)) |->
		(pix_q[0] == row_q[0]) && (pix_q[1] == row_q[1]) && (pix_q[2] == row_q[2]))
		else $error("row start edge values out of step");

endmodule
